// ----- rtl/sfp_pkg.sv -----
// shared types, constants and crc helper of the sof frame parser
package sfp_pkg;

  localparam int PAYLOAD_MAX_DEF  = 32;
  localparam int HEADER_BYTES_DEF = 6;

  // frame length and emit counter width, covers the largest allowed payload
  localparam int LEN_W     = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOF_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOF_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIRE_VERSION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_TYPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIM  = 3'd4;

  localparam logic [7:0] RST_SOF_FIRST    = 8'hAA;
  localparam logic [7:0] RST_SOF_SECOND   = 8'h55;
  localparam logic [7:0] RST_WIRE_VERSION = 8'h01;
  localparam logic [7:0] RST_REQUEST_TYPE = 8'h00;
  localparam logic [5:0] RST_PAYLOAD_LIM  = 6'd32;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] command_id;
    logic [7:0] frame_tag;
    logic [5:0] payload_length;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;
  } out_item_t;

  // one accepted frame waiting to be emitted
  typedef struct packed {
    logic [7:0]       cmd;
    logic [7:0]       tag;
    logic [LEN_W-1:0] len;
    logic             bank;
  } desc_t;

  // payload bank handed back once all its bytes are read
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- rtl/sfp_stream_if.sv -----
// valid/ready stream channel with a typed payload
interface sfp_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sfp_ram.sv -----
// generic single write, single read ram with registered read data
module sfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sfp_parser.sv -----
// front end: marker hunt, header and payload capture, crc check, frame requests
module sfp_parser import sfp_pkg::*; #(
  parameter int PayloadMax  = PAYLOAD_MAX_DEF,
  parameter int HeaderBytes = HEADER_BYTES_DEF,
  localparam int PidxW = (PayloadMax > 1) ? $clog2(PayloadMax) : 1,
  localparam int RamAw = PidxW + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  sfp_stream_if.sink           in_s,
  output logic                 push_o,
  output desc_t                push_desc_o,
  input  rel_t                 rel_i,
  output logic                 ram_we_o,
  output logic [RamAw-1:0]     ram_waddr_o,
  output logic [7:0]           ram_wdata_o
);

  localparam logic [2:0] PH_WAIT1   = 3'd0;
  localparam logic [2:0] PH_WAIT2   = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  localparam int CntMax = (HeaderBytes > PayloadMax) ? HeaderBytes : PayloadMax;
  localparam int CntW   = $clog2(CntMax + 1);

  logic [7:0] sof1_q, sof2_q, ver_q, type_q;
  logic [5:0] limit_q;

  logic [2:0]       phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;
  logic [7:0]       hdr0_q, hdr1_q, hdr2_q, hdr3_q, hdr4_q, hdr5_q;

  logic        acc;
  logic [7:0]  b;
  logic [15:0] crc_nxt;
  logic [15:0] len16;
  logic        frame_ok;
  logic        push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof1_q  <= RST_SOF_FIRST;
      sof2_q  <= RST_SOF_SECOND;
      ver_q   <= RST_WIRE_VERSION;
      type_q  <= RST_REQUEST_TYPE;
      limit_q <= RST_PAYLOAD_LIM;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SOF_FIRST:    sof1_q  <= cfg_data_i;
        REG_SOF_SECOND:   sof2_q  <= cfg_data_i;
        REG_WIRE_VERSION: ver_q   <= cfg_data_i;
        REG_REQUEST_TYPE: type_q  <= cfg_data_i;
        REG_PAYLOAD_LIM:  limit_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // payload bytes go into a bank no queued frame still owns
  assign in_s.ready = !busy_q[bank_q] || (phase_q == PH_WAIT1) ||
                      (phase_q == PH_WAIT2) || (phase_q == PH_HEADER);
  assign acc     = in_s.valid && in_s.ready;
  assign b       = in_s.data.data_byte;
  assign crc_nxt = crc16_byte(crc_q, b);
  assign len16   = {((cnt_q == CntW'(5)) ? b : hdr5_q), hdr4_q};
  assign frame_ok = (hdr0_q == ver_q) && (hdr1_q == type_q) &&
                    (len_q <= {1'b0, limit_q}) && ({b, crc_lo_q} == crc_q);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    push     = 1'b0;
    ram_we_o = 1'b0;
    if (acc) begin
      unique case (phase_q)
        PH_WAIT1: begin
          if (b == sof1_q) phase_d = PH_WAIT2;
        end
        PH_WAIT2: begin
          if (b == sof2_q) begin
            cnt_d   = '0;
            crc_d   = CRC_INIT;
            phase_d = PH_HEADER;
          end else if (b != sof1_q) begin
            phase_d = PH_WAIT1;
          end
        end
        PH_HEADER: begin
          crc_d = crc_nxt;
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q == CntW'(HeaderBytes - 1)) begin
            cnt_d = '0;
            if (len16 > 16'(PayloadMax)) begin
              phase_d = PH_WAIT1;
              len_d   = '0;
              crc_d   = CRC_INIT;
              crc_lo_d = '0;
            end else begin
              len_d   = len16[LEN_W-1:0];
              phase_d = (len16 == 16'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          ram_we_o = 1'b1;
          crc_d    = crc_nxt;
          cnt_d    = cnt_q + CntW'(1);
          if ((cnt_q + CntW'(1)) >= CntW'(len_q)) begin
            cnt_d   = '0;
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          if (cnt_q == '0) begin
            crc_lo_d = b;
            cnt_d    = CntW'(1);
          end else begin
            push     = frame_ok;
            phase_d  = PH_WAIT1;
            cnt_d    = '0;
            len_d    = '0;
            crc_d    = CRC_INIT;
            crc_lo_d = '0;
          end
        end
        default: begin
          phase_d  = PH_WAIT1;
          cnt_d    = '0;
          len_d    = '0;
          crc_d    = CRC_INIT;
          crc_lo_d = '0;
        end
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    bank_d = bank_q;
    if (rel_i.valid) busy_d[rel_i.bank] = 1'b0;
    if (push) begin
      busy_d[bank_q] = 1'b1;
      bank_d         = ~bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT1;
      cnt_q    <= '0;
      len_q    <= '0;
      crc_q    <= CRC_INIT;
      crc_lo_q <= '0;
      bank_q   <= 1'b0;
      busy_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      bank_q   <= bank_d;
      busy_q   <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (phase_q == PH_HEADER)) begin
      if (cnt_q == CntW'(0)) hdr0_q <= b;
      if (cnt_q == CntW'(1)) hdr1_q <= b;
      if (cnt_q == CntW'(2)) hdr2_q <= b;
      if (cnt_q == CntW'(3)) hdr3_q <= b;
      if (cnt_q == CntW'(4)) hdr4_q <= b;
      if (cnt_q == CntW'(5)) hdr5_q <= b;
    end
  end

  assign push_o      = push;
  assign push_desc_o = '{cmd: hdr2_q, tag: hdr3_q, len: len_q, bank: bank_q};
  assign ram_waddr_o = {bank_q, cnt_q[PidxW-1:0]};
  assign ram_wdata_o = b;

  a_push_free_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !busy_q[bank_q])
    else $error("frame request into a bank still owned by the back end");

  a_stall_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_s.ready |-> ((phase_q == PH_PAYLOAD) || (phase_q == PH_CRC)))
    else $error("input stalled outside payload or crc phase");

  a_push_flips_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (bank_q != $past(bank_q)))
    else $error("payload bank did not switch after a frame request");

endmodule

// ----- rtl/sfp_desc_queue.sv -----
// two-entry queue of accepted frame requests between front and back end
module sfp_desc_queue import sfp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  input  logic  pop_i,
  output logic  head_valid_o,
  output desc_t head_o
);

  desc_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_desc_i;
  end

  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("frame request pushed into a full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0))
    else $error("frame request popped from an empty queue");

endmodule

// ----- rtl/sfp_emitter.sv -----
// back end: walks a queued frame and emits one result per payload byte, or a single result for an empty payload
module sfp_emitter import sfp_pkg::*; #(
  parameter int PayloadMax = PAYLOAD_MAX_DEF,
  localparam int PidxW = (PayloadMax > 1) ? $clog2(PayloadMax) : 1,
  localparam int RamAw = PidxW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  desc_t            head_i,
  output logic             pop_o,
  output rel_t             rel_o,
  output logic             ram_re_o,
  output logic [RamAw-1:0] ram_raddr_o,
  input  logic [7:0]       ram_rdata_i,
  sfp_stream_if.source     out_s
);

  logic             out_valid_q;
  logic [LEN_W-1:0] k_q, k_d;
  logic [7:0]       cmd_q, tag_q;
  logic [5:0]       len_q;
  logic [4:0]       idx_q;
  logic             last_q, empty_q;

  logic adv, emit, empty_now, last_now;

  assign adv       = !out_valid_q || out_s.ready;
  assign emit      = adv && head_valid_i;
  assign empty_now = (head_i.len == '0);
  assign last_now  = empty_now || ((k_q + LEN_W'(1)) == head_i.len);
  assign k_d       = last_now ? '0 : (k_q + LEN_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (adv) out_valid_q <= emit;
      if (emit) k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      cmd_q   <= head_i.cmd;
      tag_q   <= head_i.tag;
      len_q   <= head_i.len[5:0];
      idx_q   <= k_q[4:0];
      last_q  <= last_now;
      empty_q <= empty_now;
    end
  end

  // ram data register holds the byte while the result waits
  assign ram_re_o    = emit;
  assign ram_raddr_o = {head_i.bank, k_q[PidxW-1:0]};

  assign pop_o = emit && last_now;
  assign rel_o = '{valid: emit && last_now, bank: head_i.bank};

  assign out_s.valid = out_valid_q;
  assign out_s.data  = '{command_id: cmd_q, frame_tag: tag_q, payload_length: len_q,
                         byte_index: idx_q, payload_byte: (empty_q ? 8'h00 : ram_rdata_i),
                         last: last_q};

  a_emit_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("issued result not presented");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_s.ready) |=> $stable(k_q))
    else $error("byte counter moved while the result was stalled");

endmodule

// ----- rtl/sof_frame_parser_crc16_core.sv -----
// first result: the accepted frame enters the descriptor queue, then the emitter registers the result and ram read data
// input: one byte per cycle; stalls only while both payload banks hold frames not yet read
// output: one result per cycle while out_s.ready is high and a frame is queued
// reset: async active low, clears parser state, queue and output valid; registers take defaults
// header and payload stores are not cleared; no clearing pass after reset
module sof_frame_parser_crc16_core import sfp_pkg::*; #(
  parameter int PayloadMax  = PAYLOAD_MAX_DEF,
  parameter int HeaderBytes = HEADER_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  sfp_stream_if.sink           in_s,
  sfp_stream_if.source         out_s
);

  localparam int PidxW = (PayloadMax > 1) ? $clog2(PayloadMax) : 1;
  localparam int RamAw = PidxW + 1;

  logic             push, pop, head_valid;
  desc_t            push_desc, head;
  rel_t             rel;
  logic             ram_we, ram_re;
  logic [RamAw-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  sfp_parser #(
    .PayloadMax (PayloadMax),
    .HeaderBytes(HeaderBytes)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_s),
    .push_o     (push),
    .push_desc_o(push_desc),
    .rel_i      (rel),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata)
  );

  sfp_desc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // two payload banks, one filling while the other drains
  sfp_ram #(
    .Width(8),
    .Depth(2 ** RamAw)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sfp_emitter #(
    .PayloadMax(PayloadMax)
  ) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .rel_o       (rel),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_s       (out_s)
  );

endmodule

// ----- sim/tb_sof_frame_parser_crc16_core.sv -----
// testbench of the sof frame parser: framed byte stream stimulus, scoreboard check of results
`timescale 1ns / 100ps

module tb_sof_frame_parser_crc16_core;
  import sfp_pkg::*;

  localparam int HDR_N         = HEADER_BYTES_DEF;
  localparam int PAY_N         = PAYLOAD_MAX_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_BYTES   = 55;
  localparam int SHOW_MAX      = 10;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    READ_HEADER,
    READ_PAYLOAD,
    READ_CRC
  } parse_state_e;

  typedef logic [7:0] byte_q_t[$];

  class frame_checker;
    logic [7:0]   sof_a, sof_b, version_req, type_req;
    logic [5:0]   len_limit;
    parse_state_e state;
    logic [7:0]   hdr[HDR_N];
    logic [7:0]   pay[PAY_N];
    int unsigned  count;
    int unsigned  exp_len;
    logic [15:0]  crc;
    logic [7:0]   crc_lo;
    out_item_t    pending_results[$];
    int unsigned  mismatches;

    function new();
      sof_a       = RST_SOF_FIRST;
      sof_b       = RST_SOF_SECOND;
      version_req = RST_WIRE_VERSION;
      type_req    = RST_REQUEST_TYPE;
      len_limit   = RST_PAYLOAD_LIM;
      mismatches  = 0;
      foreach (hdr[i]) hdr[i] = '0;
      foreach (pay[i]) pay[i] = '0;
      restart();
    endfunction

    // msb-first shift, feedback taken from the top crc bit and the data bit
    function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function void restart();
      state   = HUNT_FIRST;
      count   = 0;
      exp_len = 0;
      crc     = CRC_INIT;
      crc_lo  = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_SOF_FIRST:    sof_a = val;
        REG_SOF_SECOND:   sof_b = val;
        REG_WIRE_VERSION: version_req = val;
        REG_REQUEST_TYPE: type_req = val;
        REG_PAYLOAD_LIM:  len_limit = val[5:0];
        default: ;
      endcase
    endfunction

    function void queue_frame();
      out_item_t r;
      r.command_id = hdr[2];
      r.frame_tag  = hdr[3];
      if (exp_len == 0) begin
        r.payload_length = '0;
        r.byte_index     = '0;
        r.payload_byte   = '0;
        r.last           = 1'b1;
        pending_results.push_back(r);
      end else begin
        for (int k = 0; k < exp_len; k++) begin
          r.payload_length = exp_len[5:0];
          r.byte_index     = k[4:0];
          r.payload_byte   = pay[k];
          r.last           = (k + 1 == exp_len);
          pending_results.push_back(r);
        end
      end
    endfunction

    function void take_byte(logic [7:0] b);
      int unsigned len;
      case (state)
        HUNT_FIRST: if (b == sof_a) state = HUNT_SECOND;
        HUNT_SECOND: begin
          if (b == sof_b) begin
            count = 0;
            crc   = CRC_INIT;
            state = READ_HEADER;
          end else if (b != sof_a) begin
            state = HUNT_FIRST;
          end
        end
        READ_HEADER: begin
          hdr[count] = b;
          crc = crc_next(crc, b);
          count++;
          if (count >= HDR_N) begin
            len = 32'({hdr[5], hdr[4]});
            if (len > PAY_N) begin
              restart();
            end else begin
              exp_len = len;
              count   = 0;
              state   = (len != 0) ? READ_PAYLOAD : READ_CRC;
            end
          end
        end
        READ_PAYLOAD: begin
          pay[count] = b;
          crc = crc_next(crc, b);
          count++;
          if (count >= exp_len) begin
            count = 0;
            state = READ_CRC;
          end
        end
        READ_CRC: begin
          if (count == 0) begin
            crc_lo = b;
            count  = 1;
          end else begin
            if (hdr[0] == version_req && hdr[1] == type_req &&
                exp_len <= len_limit && {b, crc_lo} == crc) begin
              queue_frame();
            end
            restart();
          end
        end
        default: restart();
      endcase
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected result: cmd=%h tag=%h len=%0d idx=%0d byte=%h last=%b",
                   got.command_id, got.frame_tag, got.payload_length, got.byte_index,
                   got.payload_byte, got.last);
        return;
      end
      want = pending_results.pop_front();
      if (got.command_id !== want.command_id || got.frame_tag !== want.frame_tag ||
          got.payload_length !== want.payload_length || got.byte_index !== want.byte_index ||
          got.payload_byte !== want.payload_byte || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= SHOW_MAX) begin
          $display("bad result: want cmd=%h tag=%h len=%0d idx=%0d byte=%h last=%b",
                   want.command_id, want.frame_tag, want.payload_length, want.byte_index,
                   want.payload_byte, want.last);
          $display("             got cmd=%h tag=%h len=%0d idx=%0d byte=%h last=%b",
                   got.command_id, got.frame_tag, got.payload_length, got.byte_index,
                   got.payload_byte, got.last);
        end
      end
    endfunction

    function void check_leftover();
      if (pending_results.size() != 0) begin
        if (mismatches < SHOW_MAX)
          $display("%0d results never arrived", pending_results.size());
        mismatches += pending_results.size();
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [7:0]           cfg_data;
  int unsigned          send_idle_pct;
  int unsigned          stall_pct;
  int unsigned          cycle_cnt = 0;

  frame_checker chk = new();

  sfp_stream_if #(.payload_t(in_item_t))  in_if ();
  sfp_stream_if #(.payload_t(out_item_t)) out_if ();

  sof_frame_parser_crc16_core i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_s      (in_if),
    .out_s     (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) chk.take_byte(in_if.data.data_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) chk.match_result(out_if.data);
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_queue(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // hold the stream until every expected result is out and the parser has settled
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (chk.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    chk.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] s1, input logic [7:0] s2,
                                input logic [7:0] ver, input logic [7:0] ftype,
                                input logic [7:0] lim);
    write_cfg(REG_SOF_FIRST, s1);
    write_cfg(REG_SOF_SECOND, s2);
    write_cfg(REG_WIRE_VERSION, ver);
    write_cfg(REG_REQUEST_TYPE, ftype);
    write_cfg(REG_PAYLOAD_LIM, lim);
    write_cfg(REG_SPARE_LO, 8'($urandom));
    write_cfg(REG_SPARE_HI, 8'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic byte_q_t build_frame(logic [7:0] ver, logic [7:0] ftype,
                                          logic [7:0] cmd, logic [7:0] tag,
                                          logic [15:0] len_field, int n_pay, bit crc_good);
    byte_q_t     q;
    logic [7:0]  hb[HDR_N];
    logic [7:0]  b;
    logic [15:0] c;
    hb = '{ver, ftype, cmd, tag, len_field[7:0], len_field[15:8]};
    c  = CRC_INIT;
    q.push_back(chk.sof_a);
    q.push_back(chk.sof_b);
    foreach (hb[i]) begin
      q.push_back(hb[i]);
      c = chk.crc_next(c, hb[i]);
    end
    for (int i = 0; i < n_pay; i++) begin
      b = 8'($urandom);
      q.push_back(b);
      c = chk.crc_next(c, b);
    end
    if (!crc_good) c ^= 16'h0001 << $urandom_range(15);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    return q;
  endfunction

  // mostly short payloads, now and then the full limit
  function automatic int pick_len();
    int lim, hi, r;
    lim = int'(chk.len_limit);
    hi  = (lim < 8) ? lim : 8;
    r   = int'($urandom_range(99));
    if (r < 70) return int'($urandom_range(hi, 0));
    if (r < 92) return int'($urandom_range(lim, 0));
    return lim;
  endfunction

  task automatic send_random_frame(output int unsigned n_bytes);
    byte_q_t     q;
    int          r, n, lim;
    logic [15:0] len_field;
    logic [7:0]  ver, ftype;
    r     = int'($urandom_range(99));
    lim   = int'(chk.len_limit);
    ver   = chk.version_req;
    ftype = chk.type_req;
    n     = pick_len();
    if (r >= 65 && r < 72) ver = ver ^ 8'($urandom_range(255, 1));
    if (r >= 72 && r < 78) ftype = ftype ^ 8'($urandom_range(255, 1));
    if (r >= 86 && r < 90 && lim < PAY_N) n = int'($urandom_range(PAY_N, lim + 1));
    len_field = 16'(n);
    if (r >= 90 && r < 94) begin
      case ($urandom_range(2))
        0: len_field = 16'(PAY_N + 1);
        1: len_field = 16'($urandom_range(16'hFFFE, PAY_N + 2));
        default: len_field = 16'hFFFF;
      endcase
      n = int'($urandom_range(3));
    end
    if (r >= 97) begin
      // line noise, sometimes with stray first markers
      n = int'($urandom_range(6, 1));
      for (int i = 0; i < n; i++) q.push_back(($urandom_range(3) == 0) ? chk.sof_a : 8'($urandom));
    end else begin
      q = build_frame(ver, ftype, 8'($urandom), 8'($urandom), len_field, n,
                      !(r >= 78 && r < 86));
      if ($urandom_range(9) == 0) q.push_front(chk.sof_a);
      if (r >= 94) begin
        n = int'($urandom_range(q.size() - 1, 1));
        repeat (n) void'(q.pop_back());
      end
    end
    send_queue(q);
    n_bytes = q.size();
  endtask

  initial begin
    byte_q_t     fq;
    int unsigned sent, n_bytes;
    bit          paused;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_data      <= '0;
    in_if.valid   <= 1'b0;
    in_if.data    <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // repeated first marker, then an empty payload
    fq = build_frame(RST_WIRE_VERSION, RST_REQUEST_TYPE, 8'hFF, 8'h00, 16'd0, 0, 1'b1);
    fq.push_front(chk.sof_a);
    send_queue(fq);
    // declared length far beyond the payload store
    fq = build_frame(RST_WIRE_VERSION, RST_REQUEST_TYPE, 8'h00, 8'hFF, 16'hFFFF, 0, 1'b1);
    repeat (2) void'(fq.pop_back());
    send_queue(fq);
    // one byte payload with extreme header values
    fq = build_frame(RST_WIRE_VERSION, RST_REQUEST_TYPE, 8'h00, 8'hFF, 16'd1, 1, 1'b1);
    send_queue(fq);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: apply_settings(RST_SOF_FIRST, RST_SOF_SECOND, RST_WIRE_VERSION,
                          RST_REQUEST_TYPE, 8'(PAY_N));
        1: apply_settings(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'd0);
        2: apply_settings(8'hFF, 8'h00, 8'h00, 8'h80, 8'd16);
        default: apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom_range(PAY_N)));
      endcase
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        send_random_frame(n_bytes);
        sent += n_bytes;
        if (!paused && sent >= PHASE_BYTES / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end

    wait_idle();
    chk.check_leftover();
    if (chk.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
